>>> sv/hks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hks_pkg: shared constants and types of the homing and keyframe sequencer
// Table geometry, the elapsed-seconds divider constants and the table port
// request bundle.
// ----------------------------------------------------------------------------
package hks_pkg;

  // keyframe table geometry
  localparam int TABLE_ROWS   = 256;
  localparam int TABLE_COLS   = 11;
  localparam int VOTE_SAMPLES = 10;
  localparam int ROW_W        = $clog2(TABLE_ROWS);
  localparam int COL_W        = $clog2(TABLE_COLS);
  localparam int WORD_W       = 32;

  // seconds of a wrapping 32-bit millisecond count, plus one, fit in 23 bits
  localparam int SEC_W = 23;

  // divide by 1000 as a shift by 3 and a reciprocal multiply by 1/125
  localparam int MS_PER_SECOND = 1000;
  localparam int DIV_PRE       = 3;
  localparam int DIV_ODD       = MS_PER_SECOND >> DIV_PRE;
  localparam int DIV_X_W       = WORD_W - DIV_PRE;
  localparam int DIV_SHIFT     = DIV_X_W + 7;
  localparam int DIV_M_W       = 30;
  localparam longint unsigned DIV_MAGIC = (64'd1 << DIV_SHIFT) / DIV_ODD;

  typedef logic [WORD_W-1:0] word_t;

  // one full table row, column 0 in the low word
  typedef logic [TABLE_COLS-1:0][WORD_W-1:0] kf_row_t;

  // table port request
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    word_t            data;
  } tbl_req_t;

endpackage

>>> sv/homing_and_keyframe_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homing_and_keyframe_sequencer: vertical homing and keyframe playback
// Poll beats step the homing machine and the once-per-second keyframe player;
// write beats fill the keyframe table.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat, registered in turn by the
// capture, seconds divide, state update with table read and result stages.
// Beats are taken one per cycle unless out_ready holds the pipeline; beyond
// that, the only bubble follows a poll beat seen in the homed phase, as that
// beat may load the start time the next beat's elapsed-time subtract needs.
// The table is a 256-row by 11-word row-wide memory; per-row valid bits
// cleared at reset make it read as zero, so the block is ready right after
// reset with no clearing pass. The user must write configuration via cfg_we,
// cfg_index and cfg_wdata while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module homing_and_keyframe_sequencer import hks_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic               in_limit_first,
  input  logic [3:0]         in_limit_votes,
  input  logic               in_presence,
  input  logic               in_vertical_idle,
  input  logic               in_rotation_idle,
  input  logic [31:0]        in_elapsed_ms,
  input  logic [7:0]         in_table_row,
  input  logic [3:0]         in_table_col,
  input  logic signed [31:0] in_table_value,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_phase,
  output logic               out_keyframe_applied,
  output logic [3:0]         out_leds,
  output logic               out_light_on,
  output logic               out_pwm_enable,
  output logic [1:0]         out_rotation_cmd,
  output logic [30:0]        out_rotation_speed,
  output logic signed [31:0] out_rotation_accel,
  output logic [1:0]         out_vertical_cmd,
  output logic signed [31:0] out_vertical_target,
  output logic [30:0]        out_freq_code,
  output logic               out_restart_request
);

  typedef enum logic [2:0] {
    PH_INIT   = 3'd0,
    PH_JOG    = 3'd1,
    PH_LIMIT  = 3'd2,
    PH_ESCAPE = 3'd3,
    PH_HOMED  = 3'd4,
    PH_RUN    = 3'd5,
    PH_FIN    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    VC_NONE      = 2'd0,
    VC_MOVE      = 2'd1,
    VC_STOP_ZERO = 2'd2,
    VC_STOP_MOVE = 2'd3
  } vcmd_t;

  typedef enum logic [1:0] {
    RC_NONE = 2'd0,
    RC_RUN  = 2'd1,
    RC_STOP = 2'd2
  } rcmd_t;

  localparam logic FN_POLL          = 1'b0;
  localparam logic FN_WRITE         = 1'b1;
  localparam logic CFG_ALWAYS_START = 1'b0;
  localparam logic CFG_ESCAPE_POS   = 1'b1;

  // -100000000, the jog target far below the limit switch
  localparam word_t JOG_TARGET = 32'hFA0A1F00;
  localparam word_t FREQ_MAX   = 32'd150000;

  // keyframe row columns
  localparam int COL_SECOND = 0;
  localparam int COL_LED0   = 1;
  localparam int COL_SPEED  = 5;
  localparam int COL_ACCEL  = 6;
  localparam int COL_TARGET = 7;
  localparam int COL_LIGHT  = 8;
  localparam int COL_PWM    = 9;
  localparam int COL_FREQ   = 10;

  typedef struct packed {
    logic        func;
    logic        lim;
    logic        presence;
    logic        vidle;
    logic        ridle;
    word_t       ms;
    logic [7:0]  row;
    logic [3:0]  col;
    word_t       value;
  } item_t;

  typedef struct packed {
    phase_t           phase;
    logic             kf;
    logic [ROW_W-1:0] kf_row;
    vcmd_t            vcmd;
    word_t            vt;
  } step_t;

  // configuration registers
  logic  always_start_r;
  word_t escape_pos_r;

  // sequencer state
  phase_t           phase_r, phase_nxt;
  word_t            start_time_r, start_time_nxt;
  logic [SEC_W-1:0] cs_r, cs_nxt;
  logic [7:0]       tl_r, tl_nxt;

  // pipeline
  logic  s1_vld_r, s1_vld_nxt;
  logic  s2_vld_r, s2_vld_nxt;
  logic  s3_vld_r, s3_vld_nxt;
  logic  out_valid_r, out_valid_nxt;
  item_t s1_r, s2_r;
  step_t s3_r, s2_step;

  logic             hazard, fire1, fire2, fire3, accept;
  logic [4:0]       votes_sat;
  logic             lim_in;
  logic [SEC_W-1:0] seconds, ns;
  logic             tbl_wr, tbl_rd;
  tbl_req_t         tbl_req;
  kf_row_t          rd_row;

  // result registers
  phase_t      out_phase_r;
  logic        out_applied_r;
  logic [3:0]  out_leds_r;
  logic        out_light_r;
  logic        out_pwm_r;
  rcmd_t       out_rcmd_r;
  logic [30:0] out_rspeed_r;
  word_t       out_raccel_r;
  vcmd_t       out_vcmd_r;
  word_t       out_vt_r;
  logic [30:0] out_freq_r;
  logic        out_restart_r;

  // result stage values
  logic        o_hit;
  logic [3:0]  o_leds;
  logic        o_light, o_pwm;
  rcmd_t       o_rcmd;
  logic [30:0] o_rspeed, o_freq;
  word_t       o_raccel, o_vt;
  vcmd_t       o_vcmd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      always_start_r <= 1'b0;
      escape_pos_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALWAYS_START: always_start_r <= cfg_wdata[0];
        CFG_ESCAPE_POS:   escape_pos_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // limit vote: majority of the saturated follow-up count, gated by the first
  always_comb begin
    votes_sat = (5'(in_limit_votes) > 5'(VOTE_SAMPLES)) ? 5'(VOTE_SAMPLES)
                                                        : 5'(in_limit_votes);
    lim_in    = in_limit_first && (votes_sat > 5'(VOTE_SAMPLES / 2));
  end

  // pipeline flow; a homed poll may load the start time, so hold the
  // subtract behind it
  always_comb begin
    hazard = s2_vld_r && (s2_r.func == FN_POLL) && (phase_r == PH_HOMED);
    fire3  = s3_vld_r && (!out_valid_r || out_ready);
    fire2  = s2_vld_r && (!s3_vld_r || fire3);
    fire1  = s1_vld_r && !hazard && (!s2_vld_r || fire2);
    in_ready = !s1_vld_r || fire1;
    accept   = in_valid && in_ready;

    s1_vld_nxt    = accept ? 1'b1 : (fire1 ? 1'b0 : s1_vld_r);
    s2_vld_nxt    = fire1  ? 1'b1 : (fire2 ? 1'b0 : s2_vld_r);
    s3_vld_nxt    = fire2  ? 1'b1 : (fire3 ? 1'b0 : s3_vld_r);
    out_valid_nxt = fire3  ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      s3_vld_r    <= s3_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // beat capture and stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= '{func: in_func, lim: lim_in, presence: in_presence,
                vidle: in_vertical_idle, ridle: in_rotation_idle,
                ms: in_elapsed_ms, row: in_table_row, col: in_table_col,
                value: in_table_value};
    end
    if (fire1) begin
      s2_r <= s1_r;
    end
    if (fire2) begin
      s3_r <= s2_step;
    end
  end

  // elapsed seconds since playback start
  hks_sec_div u_div (
    .clk      (clk),
    .en       (fire1),
    .delta_ms (s1_r.ms - start_time_r),
    .seconds  (seconds)
  );

  assign ns = seconds + 1'b1;

  // homing machine, player timing and table writes
  always_comb begin
    phase_nxt      = phase_r;
    start_time_nxt = start_time_r;
    cs_nxt         = cs_r;
    tl_nxt         = tl_r;
    tbl_wr         = 1'b0;
    tbl_rd         = 1'b0;
    s2_step.vcmd   = VC_NONE;
    s2_step.vt     = '0;

    if (s2_r.func == FN_WRITE) begin
      if (({24'd0, s2_r.row} < 32'(TABLE_ROWS)) &&
          ({28'd0, s2_r.col} < 32'(TABLE_COLS))) begin
        tbl_wr = 1'b1;
        tl_nxt = s2_r.row;
      end
    end else begin
      // a pressed switch outside the back-off phases stops and zeros
      if (s2_r.lim && phase_nxt != PH_ESCAPE && phase_nxt != PH_LIMIT) begin
        phase_nxt    = PH_LIMIT;
        s2_step.vcmd = VC_STOP_ZERO;
      end

      case (phase_nxt)
        PH_INIT: begin
          phase_nxt    = PH_JOG;
          s2_step.vcmd = VC_MOVE;
          s2_step.vt   = JOG_TARGET;
        end
        PH_LIMIT: begin
          if (s2_r.vidle) begin
            phase_nxt    = PH_ESCAPE;
            s2_step.vcmd = VC_STOP_MOVE;
            s2_step.vt   = escape_pos_r;
          end
        end
        PH_ESCAPE: begin
          if (s2_r.vidle) begin
            if (s2_r.lim) begin
              s2_step.vcmd = VC_STOP_MOVE;
              s2_step.vt   = escape_pos_r;
            end else begin
              phase_nxt    = PH_HOMED;
              s2_step.vcmd = VC_STOP_ZERO;
            end
          end
        end
        PH_HOMED: begin
          if (always_start_r || s2_r.presence) begin
            phase_nxt      = PH_RUN;
            start_time_nxt = s2_r.ms;
            cs_nxt         = '0;
          end
        end
        PH_RUN: begin
          if (ns > cs_r) begin
            cs_nxt = ns;
            if (SEC_W'(tl_r) >= ns) begin
              if (32'(ns) < 32'(TABLE_ROWS)) begin
                tbl_rd = 1'b1;
              end
            end else if (s2_r.vidle && s2_r.ridle) begin
              phase_nxt = PH_FIN;
            end
          end
        end
        default: ;
      endcase
    end

    s2_step.phase  = phase_nxt;
    s2_step.kf     = tbl_rd;
    s2_step.kf_row = ns[ROW_W-1:0];

    tbl_req.wr_en = fire2 && tbl_wr;
    tbl_req.rd_en = fire2 && tbl_rd;
    tbl_req.row   = (s2_r.func == FN_WRITE) ? ROW_W'(s2_r.row) : ns[ROW_W-1:0];
    tbl_req.col   = s2_r.col[COL_W-1:0];
    tbl_req.data  = s2_r.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_INIT;
      start_time_r <= '0;
      cs_r         <= '0;
      tl_r         <= '0;
    end else if (fire2) begin
      phase_r      <= phase_nxt;
      start_time_r <= start_time_nxt;
      cs_r         <= cs_nxt;
      tl_r         <= tl_nxt;
    end
  end

  hks_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (tbl_req),
    .rd_row (rd_row)
  );

  // keyframe decode: the row applies only when its second column matches
  always_comb begin
    o_hit    = s3_r.kf && (rd_row[COL_SECOND] == WORD_W'(s3_r.kf_row));
    o_leds   = '0;
    o_light  = 1'b0;
    o_pwm    = 1'b0;
    o_rcmd   = RC_NONE;
    o_rspeed = '0;
    o_raccel = '0;
    o_freq   = '0;
    o_vcmd   = s3_r.vcmd;
    o_vt     = s3_r.vt;
    if (o_hit) begin
      for (int k = 0; k < 4; k++) begin
        o_leds[k] = (rd_row[COL_LED0 + k] == WORD_W'(1));
      end
      o_light = (rd_row[COL_LIGHT] == WORD_W'(1));
      o_pwm   = (rd_row[COL_PWM] == WORD_W'(1));
      if (!rd_row[COL_SPEED][WORD_W-1] && (rd_row[COL_SPEED] != '0)) begin
        o_rcmd   = RC_RUN;
        o_rspeed = rd_row[COL_SPEED][30:0];
        o_raccel = rd_row[COL_ACCEL];
      end else begin
        o_rcmd = RC_STOP;
      end
      if (!rd_row[COL_FREQ][WORD_W-1] && (rd_row[COL_FREQ] != '0) &&
          (rd_row[COL_FREQ] <= FREQ_MAX)) begin
        o_freq = rd_row[COL_FREQ][30:0];
      end
      o_vcmd = VC_MOVE;
      o_vt   = rd_row[COL_TARGET];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire3) begin
      out_phase_r   <= s3_r.phase;
      out_applied_r <= o_hit;
      out_leds_r    <= o_leds;
      out_light_r   <= o_light;
      out_pwm_r     <= o_pwm;
      out_rcmd_r    <= o_rcmd;
      out_rspeed_r  <= o_rspeed;
      out_raccel_r  <= o_raccel;
      out_vcmd_r    <= o_vcmd;
      out_vt_r      <= o_vt;
      out_freq_r    <= o_freq;
      out_restart_r <= (s3_r.phase == PH_FIN);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phase            = out_phase_r;
  assign out_keyframe_applied = out_applied_r;
  assign out_leds             = out_leds_r;
  assign out_light_on         = out_light_r;
  assign out_pwm_enable       = out_pwm_r;
  assign out_rotation_cmd     = out_rcmd_r;
  assign out_rotation_speed   = out_rspeed_r;
  assign out_rotation_accel   = out_raccel_r;
  assign out_vertical_cmd     = out_vcmd_r;
  assign out_vertical_target  = out_vt_r;
  assign out_freq_code        = out_freq_r;
  assign out_restart_request  = out_restart_r;

  // restart request follows the finished phase
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_restart_r == (out_phase_r == PH_FIN)))
    else $error("restart request does not match phase");

  // an applied keyframe only comes from playback and always moves the axis
  a_keyframe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_applied_r |-> (out_phase_r == PH_RUN) && (out_vcmd_r == VC_MOVE))
    else $error("keyframe applied outside playback");

  // start time only loads on a poll step in the homed phase
  a_start_time: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(start_time_r) |-> $past(fire2 && (phase_r == PH_HOMED)))
    else $error("start time changed outside the homed phase");

  // a keyframe row read is the second that playback just reached
  a_read_row: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_req.rd_en |=> (cs_r == SEC_W'($past(tbl_req.row))))
    else $error("keyframe row does not match current second");

endmodule

>>> sv/hks_sec_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hks_sec_div: elapsed milliseconds to whole seconds
// Two-stage quotient by 1000: a registered reciprocal product, then a
// one-step remainder correction.
// ----------------------------------------------------------------------------
module hks_sec_div import hks_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  word_t            delta_ms,
  output logic [SEC_W-1:0] seconds
);

  localparam int PROD_W = DIV_X_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] MAGIC = DIV_M_W'(DIV_MAGIC);

  logic [DIV_X_W-1:0] x_r;
  logic [SEC_W-1:0]   q0_r;
  logic [PROD_W-1:0]  prod;
  logic [DIV_X_W-1:0] rem;

  // floor reciprocal: estimate is the quotient or one below it
  assign prod = PROD_W'(delta_ms[WORD_W-1:DIV_PRE]) * PROD_W'(MAGIC);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= delta_ms[WORD_W-1:DIV_PRE];
      q0_r <= prod[DIV_SHIFT +: SEC_W];
    end
  end

  // correct the estimate by one when the remainder reaches the divisor
  assign rem     = x_r - DIV_X_W'(q0_r * DIV_ODD);
  assign seconds = (rem >= DIV_X_W'(DIV_ODD)) ? q0_r + 1'b1 : q0_r;

endmodule

>>> sv/hks_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hks_table: keyframe table storage
// Row-wide synchronous memory with column writes and registered row reads.
// A valid bit per row, cleared at reset, makes unwritten rows read as zero.
// ----------------------------------------------------------------------------
module hks_table import hks_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_req_t req,
  output kf_row_t  rd_row
);

  kf_row_t mem [TABLE_ROWS];

  logic [TABLE_ROWS-1:0] row_vld_r;
  kf_row_t               rd_data_r;
  logic                  rd_vld_r;
  kf_row_t               fresh_row;

  // first write to a row fills the other columns with zero
  always_comb begin
    fresh_row          = '0;
    fresh_row[req.col] = req.data;
  end

  // memory array: one column write or one row read per cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (row_vld_r[req.row]) begin
        mem[req.row][req.col] <= req.data;
      end else begin
        mem[req.row] <= fresh_row;
      end
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.row];
    end
  end

  // row valid bits and the valid flag of the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_vld_r[req.row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= row_vld_r[req.row];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule
